/* sv/msl_pkg.sv */
// Shared types and constants for the multi-shape low-frequency oscillator.
// Field widths, register indexes, shape codes, reset values and the
// multiplier control and status structs. No dependencies.
`default_nettype none

package msl_pkg;

    localparam int RATE_W     = 24;
    localparam int RATE_MAG_W = 23;
    localparam int COUNT_W    = 13;
    localparam int OFFSET_W   = 16;
    localparam int SHAPE_W    = 3;
    localparam int LEVEL_W    = 17;
    localparam int PHASE_W    = 32;
    localparam int SCALE_W    = 28;
    localparam int LCG_W      = 48;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;
    localparam int INC_SHIFT  = 24;
    localparam int INC_W      = 40;

    // Shift-add multiplier operand, product and bit counter widths.
    localparam int MUL_OP_W   = 48;
    localparam int MUL_PROD_W = 64;
    localparam int MUL_CNT_W  = 6;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_SCALE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED = 4'd1;

    localparam logic [SHAPE_W-1:0] SHAPE_SINE   = 3'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_TRI    = 3'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_SAW    = 3'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_SQUARE = 3'd3;
    localparam logic [SHAPE_W-1:0] SHAPE_HOLD   = 3'd4;

    localparam logic [SCALE_W-1:0] STEP_SCALE_RESET = 28'd22906492;
    localparam logic [LCG_W-1:0]   SEED_RESET       = 48'd1;
    localparam logic [LCG_W-1:0]   LCG_MULT         = 48'h0005_DEEC_E66D;
    localparam logic [LCG_W-1:0]   LCG_INC          = 48'h0000_0000_000B;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 17'h10000;
    localparam logic [LEVEL_W-1:0] LEVEL_HALF = 17'h08000;

    typedef struct packed {
        logic                 start;
        logic [MUL_CNT_W-1:0] nbits;
    } mul_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

`default_nettype wire

/* sv/msl_sine_rom.sv */
// Quarter-wave sine table of DEPTH+1 entries in Q1.16 with a registered read.
// Entries are built at elaboration by a fixed-point Taylor series.
// Depends on msl_pkg.
`default_nettype none

module msl_sine_rom
    import msl_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  wire logic                             clk,
    input  wire logic [$clog2(DEPTH+1)-1:0]       addr,
    output logic      [LEVEL_W-1:0]               rd_data
);

    localparam int AW = $clog2(DEPTH + 1);

    // sin(pi/2 * k/DEPTH) in Q30, series up to the x^13 term, rounded to Q16.
    function automatic logic [LEVEL_W-1:0] sin_q16(input int unsigned k);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] term;
        logic [63:0] r;
        longint      sum;
        a    = (64'd1686629713 * 64'(k)) / DEPTH;
        a2   = (a * a) >> 30;
        sum  = longint'(a);
        term = ((a * a2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * a2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * a2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * a2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * a2) >> 30) / 110;
        sum  = sum - longint'(term);
        term = ((term * a2) >> 30) / 156;
        sum  = sum + longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        r = (64'(sum) + 64'd8192) >> 14;
        if (r > 64'd65536)
        begin
            r = 64'd65536;
        end
        return r[LEVEL_W-1:0];
    endfunction

    logic [LEVEL_W-1:0] tab [DEPTH+1];

    for (genvar k = 0; k <= DEPTH; k++)
    begin : g_tab
        assign tab[k] = sin_q16(k);
    end

    always_ff @(posedge clk)
    begin
        if (addr <= AW'(DEPTH))
        begin
            rd_data <= tab[addr];
        end
        else
        begin
            rd_data <= '0;
        end
    end

endmodule

`default_nettype wire

/* sv/msl_serial_mul.sv */
// Bit-serial shift-add multiplier: one bit of operand b per cycle, MSB first.
// The product is kept modulo 2^64. Depends on msl_pkg.
`default_nettype none

module msl_serial_mul
    import msl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mul_ctrl_t             ctrl,
    input  wire logic [MUL_OP_W-1:0]   a,
    input  wire logic [MUL_OP_W-1:0]   b,
    output mul_stat_t                  stat,
    output logic      [MUL_PROD_W-1:0] prod
);

    logic [MUL_OP_W-1:0]   a_reg;
    logic [MUL_OP_W-1:0]   a_next;
    logic [MUL_OP_W-1:0]   b_reg;
    logic [MUL_OP_W-1:0]   b_next;
    logic [MUL_PROD_W-1:0] acc_reg;
    logic [MUL_PROD_W-1:0] acc_next;
    logic [MUL_CNT_W-1:0]  cnt_reg;
    logic [MUL_CNT_W-1:0]  cnt_next;
    logic                  done_reg;
    logic                  done_next;

    // Operand b arrives left-aligned, so its top bit is always the next one.
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            a_next   = a;
            b_next   = b;
            acc_next = '0;
            cnt_next = ctrl.nbits;
        end
        else if (cnt_reg != '0)
        begin
            acc_next  = (acc_reg << 1)
                      + (b_reg[MUL_OP_W-1] ? MUL_PROD_W'(a_reg) : '0);
            b_next    = b_reg << 1;
            cnt_next  = cnt_reg - MUL_CNT_W'(1);
            done_next = (cnt_reg == MUL_CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign prod      = acc_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> cnt_reg == '0)
        else $error("multiplier signals done while still counting");

    a_last_bit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == MUL_CNT_W'(1)) && !ctrl.start |=> done_reg)
        else $error("multiplier missed its done pulse");

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> cnt_reg == '0)
        else $error("multiplier restarted while busy");
`endif

endmodule

`default_nettype wire

/* sv/multi_shape_lfo.sv */
// Top level of the multi-shape low-frequency oscillator: sequencer, phase
// accumulator, shaping and sample-and-hold generator. Uses msl_pkg,
// msl_serial_mul and msl_sine_rom.
//
//  Channel  Handshake             Payload
//  input    in_valid / in_ready   rate_hz, sample_count, phase_offset, wave_shape
//  output   out_valid / out_ready level
//  config   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item at a time. Every product goes through one shift-add multiplier
// that takes one multiplier bit per cycle. Triangle, saw, square, held and
// undefined shapes need the rate and step-scale products only; sine adds
// the table position product and up to two LEVEL_W-bit products, and a
// sample-and-hold step that draws adds the LCG product. A new item is taken
// while the previous result still waits in the output register; the finished
// result waits in turn until that register is free. Configuration writes are
// always taken. Reset is asynchronous and needs no clearing pass.
`default_nettype none

module multi_shape_lfo
    import msl_pkg::*;
#(
    parameter int MAX_BLOCK        = 4096,
    parameter int SINE_TABLE_DEPTH = 256
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [RATE_W-1:0]     rate_hz,
    input  wire logic        [COUNT_W-1:0]    sample_count,
    input  wire logic        [OFFSET_W-1:0]   phase_offset,
    input  wire logic        [SHAPE_W-1:0]    wave_shape,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic             [LEVEL_W-1:0]    level,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic        [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [CFG_DATA_W-1:0] cfg_data
);

    localparam int SIN_AW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam logic [MUL_OP_W-1:0] DEPTH_B =
        MUL_OP_W'(SINE_TABLE_DEPTH) << (MUL_OP_W - SIN_AW);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] S_MUL1  = 4'd1;
    localparam logic [ST_W-1:0] S_MUL2  = 4'd2;
    localparam logic [ST_W-1:0] S_TPH   = 4'd3;
    localparam logic [ST_W-1:0] S_SHAPE = 4'd4;
    localparam logic [ST_W-1:0] S_SPOS  = 4'd5;
    localparam logic [ST_W-1:0] S_SLO   = 4'd6;
    localparam logic [ST_W-1:0] S_SHI   = 4'd7;
    localparam logic [ST_W-1:0] S_SFRAC = 4'd8;
    localparam logic [ST_W-1:0] S_SSQ   = 4'd9;
    localparam logic [ST_W-1:0] S_LCG   = 4'd10;
    localparam logic [ST_W-1:0] S_DONE  = 4'd11;

    logic [ST_W-1:0]     state_reg;
    logic [ST_W-1:0]     state_next;
    logic [PHASE_W-1:0]  phase_reg;
    logic [PHASE_W-1:0]  phase_next;
    logic                pending_reg;
    logic                pending_next;
    logic [LEVEL_W-1:0]  held_reg;
    logic [LEVEL_W-1:0]  held_next;
    logic [LCG_W-1:0]    lcg_reg;
    logic [LCG_W-1:0]    lcg_next;
    logic [SCALE_W-1:0]  scale_reg;
    logic [SCALE_W-1:0]  scale_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [LEVEL_W-1:0]  level_reg;
    logic [LEVEL_W-1:0]  level_next;
    logic [OFFSET_W-1:0] offset_reg;
    logic [OFFSET_W-1:0] offset_next;
    logic [SHAPE_W-1:0]  shape_reg;
    logic [SHAPE_W-1:0]  shape_next;
    logic [PHASE_W-1:0]  t_reg;
    logic [PHASE_W-1:0]  t_next;
    logic [SIN_AW-1:0]   idx_reg;
    logic [SIN_AW-1:0]   idx_next;
    logic [PHASE_W-1:0]  frac_reg;
    logic [PHASE_W-1:0]  frac_next;
    logic [LEVEL_W-1:0]  lo_reg;
    logic [LEVEL_W-1:0]  lo_next;
    logic [LEVEL_W-1:0]  res_reg;
    logic [LEVEL_W-1:0]  res_next;

    mul_ctrl_t             mul_ctrl;
    mul_stat_t             mul_st;
    logic [MUL_OP_W-1:0]   mul_a;
    logic [MUL_OP_W-1:0]   mul_b;
    logic [MUL_PROD_W-1:0] mul_prod;

    logic [SIN_AW-1:0]     rom_addr;
    logic [LEVEL_W-1:0]    rom_rd;

    logic [RATE_MAG_W-1:0] rate_mag;
    logic [COUNT_W-1:0]    count_sat;
    logic [PHASE_W:0]      phase_sum;
    logic [PHASE_W:0]      t_neg;
    logic [PHASE_W:0]      sine_p;
    logic [SIN_AW-1:0]     pos_idx;
    logic [LEVEL_W-1:0]    sine_d;
    logic [LEVEL_W-1:0]    sine_s;
    logic [LEVEL_W:0]      sine_sq;
    logic [LCG_W-1:0]      lcg_draw;

    msl_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mul_ctrl),
        .a     (mul_a),
        .b     (mul_b),
        .stat  (mul_st),
        .prod  (mul_prod)
    );

    msl_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .clk     (clk),
        .addr    (rom_addr),
        .rd_data (rom_rd)
    );

    // A negative rate counts as zero; the count saturates at MAX_BLOCK.
    assign rate_mag  = rate_hz[RATE_W-1] ? '0 : rate_hz[RATE_MAG_W-1:0];
    assign count_sat = (32'(sample_count) > MAX_BLOCK) ? COUNT_W'(MAX_BLOCK)
                                                       : sample_count;

    assign phase_sum = {1'b0, phase_reg}
                     + (PHASE_W+1)'(mul_prod[MUL_PROD_W-1:INC_SHIFT]);
    assign t_neg     = {1'b1, {PHASE_W{1'b0}}} - {1'b0, t_reg};
    assign sine_p    = t_reg[PHASE_W-1] ? {t_neg[PHASE_W-1:0], 1'b0}
                                        : {t_reg, 1'b0};
    assign pos_idx   = mul_prod[PHASE_W+SIN_AW-1:PHASE_W];
    assign sine_d    = (rom_rd >= lo_reg) ? (rom_rd - lo_reg) : '0;
    assign sine_s    = lo_reg + mul_prod[PHASE_W+LEVEL_W-1:PHASE_W];
    assign sine_sq   = mul_prod[2*LEVEL_W-2:LEVEL_W-2] + (LEVEL_W+1)'(1);
    assign lcg_draw  = mul_prod[LCG_W-1:0] + LCG_INC;

    assign rom_addr  = (state_reg == S_SPOS) ? pos_idx : idx_reg + SIN_AW'(1);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        pending_next   = pending_reg;
        held_next      = held_reg;
        lcg_next       = lcg_reg;
        scale_next     = scale_reg;
        out_valid_next = out_valid_reg;
        level_next     = level_reg;
        offset_next    = offset_reg;
        shape_next     = shape_reg;
        t_next         = t_reg;
        idx_next       = idx_reg;
        frac_next      = frac_reg;
        lo_next        = lo_reg;
        res_next       = res_reg;
        mul_ctrl       = '0;
        mul_a          = '0;
        mul_b          = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    offset_next    = phase_offset;
                    shape_next     = wave_shape;
                    mul_ctrl.start = 1'b1;
                    mul_ctrl.nbits = MUL_CNT_W'(RATE_MAG_W);
                    mul_a          = MUL_OP_W'(count_sat);
                    mul_b          = {rate_mag, {(MUL_OP_W-RATE_MAG_W){1'b0}}};
                    state_next     = S_MUL1;
                end
            end
            S_MUL1:
            begin
                if (mul_st.done)
                begin
                    mul_ctrl.start = 1'b1;
                    mul_ctrl.nbits = MUL_CNT_W'(SCALE_W);
                    mul_a          = mul_prod[MUL_OP_W-1:0];
                    mul_b          = {scale_reg, {(MUL_OP_W-SCALE_W){1'b0}}};
                    state_next     = S_MUL2;
                end
            end
            S_MUL2:
            begin
                // The carry into bit 32 marks one or more wraps of the cycle.
                if (mul_st.done)
                begin
                    phase_next = phase_sum[PHASE_W-1:0];
                    if (phase_sum[PHASE_W] || (mul_prod[MUL_PROD_W-1:INC_SHIFT+PHASE_W] != '0))
                    begin
                        pending_next = 1'b1;
                    end
                    state_next = S_TPH;
                end
            end
            S_TPH:
            begin
                t_next     = phase_reg + {offset_reg, {(PHASE_W-OFFSET_W){1'b0}}};
                state_next = S_SHAPE;
            end
            S_SHAPE:
            begin
                case (shape_reg)
                    SHAPE_SINE:
                    begin
                        mul_ctrl.start = 1'b1;
                        mul_ctrl.nbits = MUL_CNT_W'(SIN_AW);
                        mul_a          = MUL_OP_W'(sine_p);
                        mul_b          = DEPTH_B;
                        state_next     = S_SPOS;
                    end
                    SHAPE_TRI:
                    begin
                        res_next   = t_reg[PHASE_W-1] ? t_neg[PHASE_W-1:PHASE_W-LEVEL_W]
                                                      : t_reg[PHASE_W-1:PHASE_W-LEVEL_W];
                        state_next = S_DONE;
                    end
                    SHAPE_SAW:
                    begin
                        res_next   = {1'b0, t_reg[PHASE_W-1:PHASE_W-LEVEL_W+1]};
                        state_next = S_DONE;
                    end
                    SHAPE_SQUARE:
                    begin
                        res_next   = t_reg[PHASE_W-1] ? '0 : LEVEL_ONE;
                        state_next = S_DONE;
                    end
                    SHAPE_HOLD:
                    begin
                        if (pending_reg)
                        begin
                            mul_ctrl.start = 1'b1;
                            mul_ctrl.nbits = MUL_CNT_W'(LCG_W);
                            mul_a          = LCG_MULT;
                            mul_b          = lcg_reg;
                            state_next     = S_LCG;
                        end
                        else
                        begin
                            res_next   = held_reg;
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        res_next   = '0;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SPOS:
            begin
                if (mul_st.done)
                begin
                    idx_next   = pos_idx;
                    frac_next  = mul_prod[PHASE_W-1:0];
                    state_next = S_SLO;
                end
            end
            S_SLO:
            begin
                lo_next = rom_rd;
                // At the peak the last entry is used as it is.
                if (idx_reg == SIN_AW'(SINE_TABLE_DEPTH))
                begin
                    mul_ctrl.start = 1'b1;
                    mul_ctrl.nbits = MUL_CNT_W'(LEVEL_W);
                    mul_a          = MUL_OP_W'(rom_rd);
                    mul_b          = {rom_rd, {(MUL_OP_W-LEVEL_W){1'b0}}};
                    state_next     = S_SSQ;
                end
                else
                begin
                    state_next = S_SHI;
                end
            end
            S_SHI:
            begin
                mul_ctrl.start = 1'b1;
                mul_ctrl.nbits = MUL_CNT_W'(LEVEL_W);
                mul_a          = MUL_OP_W'(frac_reg);
                mul_b          = {sine_d, {(MUL_OP_W-LEVEL_W){1'b0}}};
                state_next     = S_SFRAC;
            end
            S_SFRAC:
            begin
                if (mul_st.done)
                begin
                    mul_ctrl.start = 1'b1;
                    mul_ctrl.nbits = MUL_CNT_W'(LEVEL_W);
                    mul_a          = MUL_OP_W'(sine_s);
                    mul_b          = {sine_s, {(MUL_OP_W-LEVEL_W){1'b0}}};
                    state_next     = S_SSQ;
                end
            end
            S_SSQ:
            begin
                // Round half up, then drop the low sixteen bits.
                if (mul_st.done)
                begin
                    res_next   = (sine_sq[LEVEL_W:1] > (LEVEL_W)'(LEVEL_ONE))
                               ? LEVEL_ONE : sine_sq[LEVEL_W:1];
                    state_next = S_DONE;
                end
            end
            S_LCG:
            begin
                if (mul_st.done)
                begin
                    lcg_next     = lcg_draw;
                    held_next    = LEVEL_W'(lcg_draw[LCG_W-1:PHASE_W]);
                    res_next     = LEVEL_W'(lcg_draw[LCG_W-1:PHASE_W]);
                    pending_next = 1'b0;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    level_next     = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_STEP_SCALE:
                begin
                    scale_next = cfg_data[SCALE_W-1:0];
                end
                REG_RANDOM_SEED:
                begin
                    lcg_next = cfg_data[LCG_W-1:0];
                end
                default:
                begin
                    scale_next = scale_next;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= '0;
            pending_reg   <= 1'b1;
            held_reg      <= LEVEL_HALF;
            lcg_reg       <= SEED_RESET;
            scale_reg     <= STEP_SCALE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pending_reg   <= pending_next;
            held_reg      <= held_next;
            lcg_reg       <= lcg_next;
            scale_reg     <= scale_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg  <= level_next;
        offset_reg <= offset_next;
        shape_reg  <= shape_next;
        t_reg      <= t_next;
        idx_reg    <= idx_next;
        frac_reg   <= frac_next;
        lo_reg     <= lo_next;
        res_reg    <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign level     = level_reg;
    assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_idle_mul_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !mul_st.busy)
        else $error("multiplier busy while the sequencer is idle");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_MUL1 && mul_st.busy)
        else $error("accepted item did not start the first product");

    a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_valid_reg && !out_ready |=> state_reg == S_DONE)
        else $error("result left while the output register was full");

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("output raised outside completion");
`endif

endmodule

`default_nettype wire
